[rtl/crc_checked_frame_receiver_assert.svh]
// Assertion macros used by the frame receiver front end.
`ifndef CRC_CHECKED_FRAME_RECEIVER_ASSERT_SVH
`define CRC_CHECKED_FRAME_RECEIVER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CCFR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("frame receiver check failed");

// Consequent must hold in the cycle after the antecedent.
`define CCFR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("frame receiver check failed");

`endif

[rtl/ccfr_pkg.sv]
// Types, constants and the CRC-32 helper for the frame receiver.
`timescale 1ns / 1ps
`default_nettype none
package ccfr_pkg;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_HALTED  = 2'd2
    } t_phase;

    localparam logic [1:0] VERDICT_TENTATIVE = 2'd0;
    localparam logic [1:0] VERDICT_GOOD      = 2'd1;
    localparam logic [1:0] VERDICT_BAD_HDR   = 2'd2;
    localparam logic [1:0] VERDICT_BAD_CRC   = 2'd3;

    localparam logic [3:0]  HDR_LAST_POS    = 4'd15;
    localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1536;
    localparam logic [31:0] CRC_POLY        = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT        = 32'hFFFFFFFF;
    localparam logic [7:0]  MAGIC [4]       = '{8'h43, 8'h46, 8'h30, 8'h31};

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        logic [1:0] verdict;
    } t_result;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0] data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

[rtl/ccfr_front.sv]
// Front end: header parse, sequence and length checks, payload CRC, result classification.
`timescale 1ns / 1ps
`default_nettype none
`include "crc_checked_frame_receiver_assert.svh"
module ccfr_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [7:0]         i_rx_byte,
    input  wire logic               i_cfg_valid,
    input  wire logic [15:0]        i_cfg_max_payload_bytes,
    input  wire logic               i_q_full,
    output logic                    o_push,
    output ccfr_pkg::t_result       o_push_data
);

    ccfr_pkg::t_phase r_phase, n_phase;
    logic [15:0] r_max;
    logic [15:0] r_pos, n_pos;
    logic [31:0] r_exp_seq, n_exp_seq;
    logic        r_hdr_good, n_hdr_good;
    logic [31:0] r_len, n_len;
    logic [31:0] r_chk, n_chk;
    logic [31:0] r_crc, n_crc;

    logic        accept;
    logic [3:0]  hdr_pos;
    logic [4:0]  sh;
    logic [31:0] byte_sh;
    logic [31:0] crc_upd;
    logic        hdr_bad;
    logic        last_payload;
    logic        crc_ok;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign hdr_pos    = r_pos[3:0];
    assign sh         = {hdr_pos[1:0], 3'b000};
    assign byte_sh    = {24'd0, i_rx_byte} << sh;
    assign crc_upd    = ccfr_pkg::crc_byte(r_crc, i_rx_byte);
    assign hdr_bad    = !r_hdr_good || (r_len == 32'd0) || (r_len > {16'd0, r_max});
    assign last_payload = ({1'b0, r_pos} + 17'd1) >= r_len[16:0];
    assign crc_ok     = (~crc_upd) == r_chk;

    // next state
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            ccfr_pkg::PH_HEADER: begin
                if (accept && hdr_pos == ccfr_pkg::HDR_LAST_POS) begin
                    n_phase = hdr_bad ? ccfr_pkg::PH_HALTED : ccfr_pkg::PH_PAYLOAD;
                end
            end
            ccfr_pkg::PH_PAYLOAD: begin
                if (accept && last_payload) begin
                    n_phase = crc_ok ? ccfr_pkg::PH_HEADER : ccfr_pkg::PH_HALTED;
                end
            end
            ccfr_pkg::PH_HALTED: n_phase = ccfr_pkg::PH_HALTED;
            default:             n_phase = ccfr_pkg::PH_HEADER;
        endcase
    end

    // outputs
    always_comb begin
        o_push      = 1'b0;
        o_push_data = '0;
        case (r_phase)
            ccfr_pkg::PH_HEADER: begin
                if (accept && hdr_pos == ccfr_pkg::HDR_LAST_POS && hdr_bad) begin
                    o_push                = 1'b1;
                    o_push_data.frame_end = 1'b1;
                    o_push_data.verdict   = ccfr_pkg::VERDICT_BAD_HDR;
                end
            end
            ccfr_pkg::PH_PAYLOAD: begin
                if (accept) begin
                    o_push               = 1'b1;
                    o_push_data.out_byte = i_rx_byte;
                    if (last_payload) begin
                        o_push_data.frame_end = 1'b1;
                        o_push_data.verdict   = crc_ok ? ccfr_pkg::VERDICT_GOOD
                                                       : ccfr_pkg::VERDICT_BAD_CRC;
                    end else begin
                        o_push_data.verdict   = ccfr_pkg::VERDICT_TENTATIVE;
                    end
                end
            end
            default: o_push = 1'b0;
        endcase
    end

    // datapath
    always_comb begin
        n_pos      = r_pos;
        n_exp_seq  = r_exp_seq;
        n_hdr_good = r_hdr_good;
        n_len      = r_len;
        n_chk      = r_chk;
        n_crc      = r_crc;
        if (accept) begin
            case (r_phase)
                ccfr_pkg::PH_HEADER: begin
                    case (hdr_pos[3:2])
                        2'd0: begin
                            if (i_rx_byte != ccfr_pkg::MAGIC[hdr_pos[1:0]]) begin
                                n_hdr_good = 1'b0;
                            end
                        end
                        2'd1: begin
                            if (i_rx_byte != r_exp_seq[sh +: 8]) begin
                                n_hdr_good = 1'b0;
                            end
                        end
                        2'd2:    n_len = r_len | byte_sh;
                        default: n_chk = r_chk | byte_sh;
                    endcase
                    n_pos = (hdr_pos == ccfr_pkg::HDR_LAST_POS) ? 16'd0 : r_pos + 16'd1;
                    n_crc = ccfr_pkg::CRC_INIT;
                end
                ccfr_pkg::PH_PAYLOAD: begin
                    n_crc = crc_upd;
                    if (last_payload) begin
                        if (crc_ok) begin
                            n_exp_seq  = r_exp_seq + 32'd1;
                            n_pos      = 16'd0;
                            n_hdr_good = 1'b1;
                            n_len      = 32'd0;
                            n_chk      = 32'd0;
                            n_crc      = ccfr_pkg::CRC_INIT;
                        end
                    end else begin
                        n_pos = r_pos + 16'd1;
                    end
                end
                default: n_pos = r_pos;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= ccfr_pkg::PH_HEADER;
            r_max      <= ccfr_pkg::MAX_PAYLOAD_RST;
            r_pos      <= 16'd0;
            r_exp_seq  <= 32'd0;
            r_hdr_good <= 1'b1;
            r_len      <= 32'd0;
            r_chk      <= 32'd0;
            r_crc      <= ccfr_pkg::CRC_INIT;
        end else begin
            r_phase    <= n_phase;
            r_pos      <= n_pos;
            r_exp_seq  <= n_exp_seq;
            r_hdr_good <= n_hdr_good;
            r_len      <= n_len;
            r_chk      <= n_chk;
            r_crc      <= n_crc;
            if (i_cfg_valid) begin
                r_max <= i_cfg_max_payload_bytes;
            end
        end
    end

    `CCFR_ASSERT_SAME(a_push_needs_accept, o_push, accept)
    `CCFR_ASSERT_NEXT(a_halt_sticks, i_rst_n && r_phase == ccfr_pkg::PH_HALTED,
                      r_phase == ccfr_pkg::PH_HALTED)
    `CCFR_ASSERT_SAME(a_payload_len_bounded, r_phase == ccfr_pkg::PH_PAYLOAD,
                      r_len[31:16] == 16'd0 && r_len != 32'd0)
    `CCFR_ASSERT_NEXT(a_seq_steps_on_good,
                      i_rst_n && o_push && o_push_data.verdict == ccfr_pkg::VERDICT_GOOD,
                      r_exp_seq == $past(r_exp_seq) + 32'd1)

endmodule
`default_nettype wire

[rtl/ccfr_queue.sv]
// Short result queue between the front end and the output stage.
`timescale 1ns / 1ps
`default_nettype none
module ccfr_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire ccfr_pkg::t_result  i_push_data,
    output logic                    o_full,
    input  wire logic               i_pop,
    output logic                    o_empty,
    output ccfr_pkg::t_result       o_pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ccfr_pkg::t_result r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, n_wr;
    logic [PTR_W-1:0]  r_rd, n_rd;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              do_push, do_pop;

    assign o_full     = r_cnt == CNT_W'(DEPTH);
    assign o_empty    = r_cnt == '0;
    assign o_pop_data = r_mem[r_rd];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt + CNT_W'(do_push) - CNT_W'(do_pop);
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire

[rtl/ccfr_back.sv]
// Output stage: drains the result queue into the registered output channel.
`timescale 1ns / 1ps
`default_nettype none
module ccfr_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_empty,
    input  wire ccfr_pkg::t_result  i_q_data,
    output logic                    o_pop,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output ccfr_pkg::t_result       o_out_data
);

    logic              r_valid;
    ccfr_pkg::t_result r_data;

    assign o_pop       = !i_q_empty && (!r_valid || !i_out_stall);
    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_q_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

endmodule
`default_nettype wire

[rtl/crc_checked_frame_receiver.sv]
// Top level of the CRC-checked sequenced frame receiver.
`timescale 1ns / 1ps
`default_nettype none
// Takes one stream byte per cycle while o_in_stall is low; a result passes through the
// result queue and then the output register. Each frame is a 16-byte header ("CF01",
// then little-endian sequence, length and payload CRC-32) and its payload; payload
// bytes come out with verdict 0, the last one with frame_end set and verdict 1 (good)
// or 3 (bad CRC); a bad header gives one result with verdict 2.
// Any error halts the receiver until reset; bytes are still taken but give nothing.
// The CRC unit handles a whole byte per cycle; o_in_stall rises only when the
// QUEUE_DEPTH-entry result queue is full. Write max_payload_bytes only while idle.
module crc_checked_frame_receiver #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_out_byte,
    output logic             o_frame_end,
    output logic [1:0]       o_verdict,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_max_payload_bytes
);

    logic              push, q_full, pop, q_empty;
    ccfr_pkg::t_result push_data, q_data, out_data;

    assign o_cfg_ready = 1'b1;

    ccfr_front u_front (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_in_valid              (i_in_valid),
        .o_in_stall              (o_in_stall),
        .i_rx_byte               (i_rx_byte),
        .i_cfg_valid             (i_cfg_valid),
        .i_cfg_max_payload_bytes (i_cfg_max_payload_bytes),
        .i_q_full                (q_full),
        .o_push                  (push),
        .o_push_data             (push_data)
    );

    ccfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (q_full),
        .i_pop       (pop),
        .o_empty     (q_empty),
        .o_pop_data  (q_data)
    );

    ccfr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_data    (q_data),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (out_data)
    );

    assign o_out_byte  = out_data.out_byte;
    assign o_frame_end = out_data.frame_end;
    assign o_verdict   = out_data.verdict;

endmodule
`default_nettype wire
